@@ hdl/palette_rle_pixel_decoder_unit_assert.svh @@
// Assertion macros for the palette RLE pixel decoder.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef PALETTE_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH
`define PALETTE_RLE_PIXEL_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PRDU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PRDU_ASSERT_NEVER(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
        else $error("forbidden condition seen");
`else
`define PRDU_ASSERT(lbl, clk, rst_n, prop)
`define PRDU_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

@@ hdl/prdu_pkg.sv @@
// Shared types and constants for the palette RLE pixel decoder.
// No dependencies; imported by every module of the block.
package prdu_pkg;

    localparam int SIDE_W      = 11;
    localparam int PIX_W       = 2 * SIDE_W;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 3;
    localparam int PIX_PER_GRP = 4;
    localparam int PAL_DEPTH   = 256;
    localparam int PAL_AW      = $clog2(PAL_DEPTH);
    localparam int PAL_BYTES_W = PAL_AW + 2;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              blob_end;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic [BYTE_W-1:0] alpha;
        logic [CNT_W-1:0]  pixel_count;
        logic              run_end;
        logic              image_full;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic run_start;
        logic last_group;
    } t_dp_sts;

endpackage

@@ hdl/palette_rle_pixel_decoder_unit.sv @@
// Palette RLE pixel decoder, top level. Header, palette and index bytes are
// accepted back to back; after a run byte is accepted, one pixel group per cycle
// (ceil(run/4), at most 64) leaves the result register, longer under output stall.
// The run byte enters S_EMIT, where each group loads into the result register.
// Synchronous active-low reset clears control state and the size registers; the
// palette memory is not cleared and holds garbage until written.
module palette_rle_pixel_decoder_unit
    import prdu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIDE_W-1:0]    i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    prdu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    prdu_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_out_data)
    );

endmodule

@@ hdl/prdu_dpath.sv @@
// Datapath: blob parser, palette memory, pixel counters and result register.
// Depends on prdu_pkg; driven by prdu_ctrl through t_dp_cmd / t_dp_sts.
`include "palette_rle_pixel_decoder_unit_assert.svh"
module prdu_dpath
    import prdu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SIDE_W-1:0]    i_cfg_data,
    input  t_in_item             i_item,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output t_out_item            o_result
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_INDEX,
        PH_RUN
    } t_phase;

    logic [4*BYTE_W-1:0] mem [PAL_DEPTH];

    t_phase                 r_phase, n_phase;
    logic [BYTE_W-1:0]      r_color_total, n_color_total;
    logic [PAL_BYTES_W-1:0] r_bytes_left, n_bytes_left;
    logic [BYTE_W-1:0]      r_held_index, n_held_index;
    logic [PIX_W-1:0]       r_pixels_done, n_pixels_done;
    logic                   r_stopped, n_stopped;
    logic [SIDE_W-1:0]      r_width, n_width;
    logic [SIDE_W-1:0]      r_height, n_height;
    logic [PIX_W-1:0]       r_total;
    logic [3*BYTE_W-1:0]    r_word;
    logic [4*BYTE_W-1:0]    r_entry;
    logic [BYTE_W-1:0]      r_left;
    logic                   r_full;
    t_out_item              r_result;

    logic [PAL_BYTES_W-1:0] pal_pos;
    logic [PIX_W-1:0]       remaining;
    logic [PIX_W-1:0]       run_ext;
    logic                   run_go;
    logic [BYTE_W-1:0]      run_clip;
    logic                   grp_last;
    logic [CNT_W-1:0]       grp_cnt;
    logic                   pal_we;

    assign n_width   = (i_cfg_valid && (i_cfg_index == CFG_IMAGE_WIDTH)) ? i_cfg_data : r_width;
    assign n_height  = (i_cfg_valid && (i_cfg_index == CFG_IMAGE_HEIGHT)) ? i_cfg_data
                                                                           : r_height;
    assign pal_pos   = {r_color_total, 2'b00} - r_bytes_left;
    assign remaining = r_total - r_pixels_done;
    assign run_ext   = PIX_W'(i_item.data_byte);
    assign run_go    = (r_phase == PH_RUN) && !r_stopped
                    && (r_held_index < r_color_total)
                    && (i_item.data_byte != '0)
                    && (r_pixels_done < r_total);
    assign run_clip  = (run_ext > remaining) ? remaining[BYTE_W-1:0] : i_item.data_byte;
    assign grp_last  = r_left <= BYTE_W'(PIX_PER_GRP);
    assign grp_cnt   = grp_last ? r_left[CNT_W-1:0] : CNT_W'(PIX_PER_GRP);
    assign pal_we    = i_cmd.accept && (r_phase == PH_PALETTE) && (pal_pos[1:0] == 2'b11);

    assign o_sts.run_start  = run_go;
    assign o_sts.last_group = grp_last;
    assign o_result         = r_result;

    always_comb begin
        n_phase       = r_phase;
        n_color_total = r_color_total;
        n_bytes_left  = r_bytes_left;
        n_held_index  = r_held_index;
        n_pixels_done = r_pixels_done;
        n_stopped     = r_stopped;
        if (i_cmd.accept) begin
            case (r_phase)
                PH_HEADER: begin
                    n_color_total = i_item.data_byte;
                    n_bytes_left  = {i_item.data_byte, 2'b00};
                    n_pixels_done = '0;
                    n_stopped     = 1'b0;
                    n_held_index  = '0;
                    n_phase       = (i_item.data_byte == '0) ? PH_INDEX : PH_PALETTE;
                end
                PH_PALETTE: begin
                    n_bytes_left = r_bytes_left - 1'b1;
                    if (r_bytes_left == PAL_BYTES_W'(1)) begin
                        n_phase = PH_INDEX;
                    end
                end
                PH_INDEX: begin
                    n_held_index = i_item.data_byte;
                    n_phase      = PH_RUN;
                end
                default: begin
                    n_phase = PH_INDEX;
                    if (!r_stopped && (r_held_index >= r_color_total)) begin
                        n_stopped = 1'b1;
                    end
                    if (run_go) begin
                        n_pixels_done = r_pixels_done + PIX_W'(run_clip);
                    end
                end
            endcase
            if (i_item.blob_end) begin
                n_phase       = PH_HEADER;
                n_color_total = '0;
                n_bytes_left  = '0;
                n_held_index  = '0;
                n_pixels_done = '0;
                n_stopped     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_color_total <= '0;
            r_bytes_left  <= '0;
            r_held_index  <= '0;
            r_pixels_done <= '0;
            r_stopped     <= 1'b0;
            r_width       <= '0;
            r_height      <= '0;
            r_total       <= '0;
            r_left        <= '0;
        end else begin
            r_phase       <= n_phase;
            r_color_total <= n_color_total;
            r_bytes_left  <= n_bytes_left;
            r_held_index  <= n_held_index;
            r_pixels_done <= n_pixels_done;
            r_stopped     <= n_stopped;
            r_width       <= n_width;
            r_height      <= n_height;
            r_total       <= PIX_W'(n_width) * PIX_W'(n_height);
            if (i_cmd.accept && run_go) begin
                r_left <= run_clip;
            end else if (i_cmd.emit) begin
                r_left <= r_left - BYTE_W'(grp_cnt);
            end
        end
    end

    // palette memory and payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (r_phase == PH_PALETTE)) begin
            case (pal_pos[1:0])
                2'd0:    r_word[BYTE_W-1:0]          <= i_item.data_byte;
                2'd1:    r_word[2*BYTE_W-1:BYTE_W]   <= i_item.data_byte;
                2'd2:    r_word[3*BYTE_W-1:2*BYTE_W] <= i_item.data_byte;
                default: ;
            endcase
        end
        if (pal_we) begin
            mem[pal_pos[PAL_BYTES_W-1:2]] <= {i_item.data_byte, r_word};
        end
        if (i_cmd.accept && (r_phase == PH_INDEX)) begin
            r_entry <= mem[i_item.data_byte];
        end
        if (i_cmd.accept && run_go) begin
            r_full <= run_ext >= remaining;
        end
        if (i_cmd.emit) begin
            r_result.red         <= r_entry[BYTE_W-1:0];
            r_result.green       <= r_entry[2*BYTE_W-1:BYTE_W];
            r_result.blue        <= r_entry[3*BYTE_W-1:2*BYTE_W];
            r_result.alpha       <= r_entry[4*BYTE_W-1:3*BYTE_W];
            r_result.pixel_count <= grp_cnt;
            r_result.run_end     <= grp_last;
            r_result.image_full  <= grp_last && r_full;
        end
    end

    `PRDU_ASSERT(a_emit_has_pixels, i_clk, i_rst_n, i_cmd.emit |-> (r_left != '0))
    `PRDU_ASSERT(a_last_group_drains, i_clk, i_rst_n, (i_cmd.emit && grp_last) |=> (r_left == '0))
    `PRDU_ASSERT(a_blob_end_clears, i_clk, i_rst_n, (i_cmd.accept && i_item.blob_end) |=> (r_phase == PH_HEADER && r_pixels_done == '0 && !r_stopped))
    `PRDU_ASSERT_NEVER(a_pixels_over_total, i_clk, i_rst_n, (r_phase == PH_RUN) && (r_pixels_done > r_total))

endmodule

@@ hdl/prdu_ctrl.sv @@
// Controller: input/output handshakes and the run emission sequence.
// Depends on prdu_pkg; commands prdu_dpath through t_dp_cmd / t_dp_sts.
`include "palette_rle_pixel_decoder_unit_assert.svh"
module prdu_ctrl
    import prdu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic {
        S_ACCEPT,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   load;

    assign o_in_ready   = (r_state == S_ACCEPT);
    assign o_out_valid  = r_out_valid;
    assign load         = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign o_cmd.accept = i_in_valid && o_in_ready;
    assign o_cmd.emit   = load;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_ACCEPT: begin
                if (o_cmd.accept && i_sts.run_start) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    if (i_sts.last_group) begin
                        n_state = S_ACCEPT;
                    end
                end
            end
            default: n_state = S_ACCEPT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `PRDU_ASSERT(a_run_enters_emit, i_clk, i_rst_n, (o_cmd.accept && i_sts.run_start) |=> (r_state == S_EMIT && !o_in_ready))
    `PRDU_ASSERT(a_stall_holds_emit, i_clk, i_rst_n, (r_state == S_EMIT && r_out_valid && !i_out_ready) |=> (r_state == S_EMIT))
    `PRDU_ASSERT(a_emit_sets_valid, i_clk, i_rst_n, o_cmd.emit |=> r_out_valid)

endmodule
